### src/rwps_pkg.sv
// ----------------------------------------------------------------------------
// rwps_pkg
// Shared types and constants for the rolling window packet statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package rwps_pkg;

   // Counter geometry
   localparam int CTR_W   = 32;
   localparam int NUM_CTR = 8;
   localparam int TIME_W  = 32;

   // Default snapshot ring depth
   localparam int DEFAULT_RING_DEPTH = 64;

   // Register file
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE        = 2'd0,
      CSR_SCAN_INTERVAL = 2'd1,
      CSR_WINDOW        = 2'd2
   } csr_index_type;

   localparam logic [CSR_DATA_W-1:0] SCAN_INTERVAL_RESET = 32'd5000;
   localparam logic [CSR_DATA_W-1:0] WINDOW_RESET        = 32'd300000;

   typedef struct packed {
      logic              enable;
      logic [TIME_W-1:0] scan_interval_ms;
      logic [TIME_W-1:0] window_ms;
   } cfg_type;

   // Eight counters side by side, index 0 = local good .. 7 = remote resync
   typedef logic [NUM_CTR-1:0][CTR_W-1:0] ctr_vec_type;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic [CTR_W-1:0]  local_good;
      logic [CTR_W-1:0]  local_late;
      logic [CTR_W-1:0]  local_lost;
      logic [CTR_W-1:0]  local_resync;
      logic [CTR_W-1:0]  remote_good;
      logic [CTR_W-1:0]  remote_late;
      logic [CTR_W-1:0]  remote_lost;
      logic [CTR_W-1:0]  remote_resync;
   } req_type;

   typedef struct packed {
      logic             sampled;
      logic [CTR_W-1:0] roll_local_good;
      logic [CTR_W-1:0] roll_local_late;
      logic [CTR_W-1:0] roll_local_lost;
      logic [CTR_W-1:0] roll_local_resync;
      logic [CTR_W-1:0] roll_remote_good;
      logic [CTR_W-1:0] roll_remote_late;
      logic [CTR_W-1:0] roll_remote_lost;
      logic [CTR_W-1:0] roll_remote_resync;
   } rsp_type;

   // Gather the counters of a request into one vector
   function automatic ctr_vec_type req_counters(req_type r);
      ctr_vec_type v;
      v[0] = r.local_good;
      v[1] = r.local_late;
      v[2] = r.local_lost;
      v[3] = r.local_resync;
      v[4] = r.remote_good;
      v[5] = r.remote_late;
      v[6] = r.remote_lost;
      v[7] = r.remote_resync;
      return v;
   endfunction

   // Build a response beat from the flag and the rolling values
   function automatic rsp_type make_rsp(logic s, ctr_vec_type v);
      rsp_type r;
      r.sampled            = s;
      r.roll_local_good    = v[0];
      r.roll_local_late    = v[1];
      r.roll_local_lost    = v[2];
      r.roll_local_resync  = v[3];
      r.roll_remote_good   = v[4];
      r.roll_remote_late   = v[5];
      r.roll_remote_lost   = v[6];
      r.roll_remote_resync = v[7];
      return r;
   endfunction

endpackage

`default_nettype wire

### src/rwps_ram.sv
// ----------------------------------------------------------------------------
// rwps_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rwps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### src/rwps_csr.sv
// ----------------------------------------------------------------------------
// rwps_csr
// Configuration registers: enable, scan interval and window length.
// ----------------------------------------------------------------------------
`default_nettype none

module rwps_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [rwps_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rwps_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output rwps_pkg::cfg_type                       cfg
);

   import rwps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Always take writes; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE:        cfg_in.enable           = csr_wdata[0];
            CSR_SCAN_INTERVAL: cfg_in.scan_interval_ms = csr_wdata;
            CSR_WINDOW:        cfg_in.window_ms        = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable           <= 1'b0;
         cfg_ff.scan_interval_ms <= SCAN_INTERVAL_RESET;
         cfg_ff.window_ms        <= WINDOW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### src/rwps_seq.sv
// ----------------------------------------------------------------------------
// rwps_seq
// Request sequencer: sample decision, ring push, stale scan over the time
// memory, rolling value update and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module rwps_seq #(
   parameter int RING_DEPTH = rwps_pkg::DEFAULT_RING_DEPTH,
   localparam int IDX_W     = $clog2(RING_DEPTH),
   localparam int CNT_W     = $clog2(RING_DEPTH + 1)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire rwps_pkg::cfg_type                   cfg,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire rwps_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output rwps_pkg::rsp_type                        rsp_data,
   // ring memory ports
   output logic                                     mem_wr_en,
   output logic [IDX_W-1:0]                         mem_wr_addr,
   output logic [IDX_W-1:0]                         mem_rd_addr,
   input  wire logic [rwps_pkg::TIME_W-1:0]         time_rd_data,
   input  wire rwps_pkg::ctr_vec_type               ctr_rd_data
);

   import rwps_pkg::*;

   localparam int SUM_W = CNT_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_READ,
      ST_CHECK,
      ST_OUT
   } state_type;

   state_type           state_ff,     state_in;
   req_type             cur_ff,       cur_in;
   logic                sampled_ff,   sampled_in;
   logic [TIME_W-1:0]   last_ff,      last_in;
   logic                once_ff,      once_in;
   logic [IDX_W-1:0]    oldest_ff,    oldest_in;
   logic [CNT_W-1:0]    fill_ff,      fill_in;
   ctr_vec_type         roll_ff,      roll_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff,  rsp_data_in;

   logic [TIME_W-1:0]   since_last;
   logic                take_sample;
   logic                ring_full;
   logic [IDX_W-1:0]    oldest_adj;
   logic [CNT_W-1:0]    fill_adj;
   logic [SUM_W-1:0]    slot_sum;
   logic [IDX_W-1:0]    slot;
   logic [TIME_W-1:0]   age;
   logic                stale;
   logic [IDX_W-1:0]    oldest_next;
   ctr_vec_type         cur_ctr;

   // Advance a ring index with wrap
   function automatic logic [IDX_W-1:0] ring_inc(logic [IDX_W-1:0] i);
      if (i == IDX_W'(RING_DEPTH - 1)) begin
         return '0;
      end
      return i + IDX_W'(1);
   endfunction

   // Sample decision on the incoming request
   assign since_last  = req_data.now_ms - last_ff;
   assign take_sample = cfg.enable &&
                        (!once_ff || (since_last >= cfg.scan_interval_ms));

   // Push slot: drop the oldest entry first when the ring is full
   assign ring_full  = (fill_ff == CNT_W'(RING_DEPTH));
   assign oldest_adj = ring_full ? ring_inc(oldest_ff) : oldest_ff;
   assign fill_adj   = ring_full ? CNT_W'(RING_DEPTH - 1) : fill_ff;
   assign slot_sum   = SUM_W'(oldest_adj) + SUM_W'(fill_adj);
   assign slot       = (slot_sum >= SUM_W'(RING_DEPTH)) ?
                       IDX_W'(slot_sum - SUM_W'(RING_DEPTH)) : IDX_W'(slot_sum);

   // Age of the oldest kept snapshot
   assign age         = cur_ff.now_ms - time_rd_data;
   assign stale       = (fill_ff != '0) && (age > cfg.window_ms);
   assign oldest_next = ring_inc(oldest_ff);
   assign cur_ctr     = req_counters(cur_ff);

   // Memory control
   assign mem_wr_en   = (state_ff == ST_PUSH);
   assign mem_wr_addr = slot;
   assign mem_rd_addr = (state_ff == ST_CHECK && stale) ? oldest_next : oldest_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      sampled_in   = sampled_ff;
      last_in      = last_ff;
      once_in      = once_ff;
      oldest_in    = oldest_ff;
      fill_in      = fill_ff;
      roll_in      = roll_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // Retire the delivered beat
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cur_in     = req_data;
               sampled_in = take_sample;
               if (take_sample) begin
                  once_in  = 1'b1;
                  last_in  = req_data.now_ms;
                  state_in = ST_PUSH;
               end else begin
                  state_in = ST_OUT;
               end
            end
         end
         // Write the snapshot and commit the pointers
         ST_PUSH: begin
            oldest_in = oldest_adj;
            fill_in   = fill_adj + CNT_W'(1);
            state_in  = ST_READ;
         end
         // Read address is oldest_ff this cycle
         ST_READ: begin
            state_in = ST_CHECK;
         end
         // Drop stale entries one a cycle, then form the deltas
         ST_CHECK: begin
            if (stale) begin
               oldest_in = oldest_next;
               fill_in   = fill_ff - CNT_W'(1);
            end else begin
               if (fill_ff != '0) begin
                  for (int k = 0; k < NUM_CTR; k++) begin
                     roll_in[k] = cur_ctr[k] - ctr_rd_data[k];
                  end
               end
               state_in = ST_OUT;
            end
         end
         // Hand the result to the output register once it is free
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = make_rsp(sampled_ff, roll_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= '0;
         once_ff      <= 1'b0;
         oldest_ff    <= '0;
         fill_ff      <= '0;
         roll_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         once_ff      <= once_in;
         oldest_ff    <= oldest_in;
         fill_ff      <= fill_in;
         roll_ff      <= roll_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      sampled_ff  <= sampled_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### src/rolling_window_packet_stats.sv
// ----------------------------------------------------------------------------
// rolling_window_packet_stats
// Sliding window deltas of eight packet counters over a snapshot ring.
// ----------------------------------------------------------------------------
// Each request beat returns one response beat. A request that stores no
// snapshot (disabled, or scan interval not yet elapsed) goes from accept
// to the output state, which registers rsp_valid once the output register
// is free. A sampling request first passes the push, read and check states:
// the stale scan reads the time memory one entry a cycle through its
// registered read port. Requests are handled one at a time; req_stall is
// high while a request is in flight. The response register lets the next
// request be accepted while a result waits. The snapshot memories need no
// clearing pass; the block is ready after reset.
`default_nettype none

module rolling_window_packet_stats #(
   parameter int RING_DEPTH = rwps_pkg::DEFAULT_RING_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire rwps_pkg::req_type                req_data,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output rwps_pkg::rsp_type                     rsp_data,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [rwps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rwps_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import rwps_pkg::*;

   localparam int IDX_W = $clog2(RING_DEPTH);

   cfg_type              cfg;
   logic                 mem_wr_en;
   logic [IDX_W-1:0]     mem_wr_addr;
   logic [IDX_W-1:0]     mem_rd_addr;
   logic [TIME_W-1:0]    time_rd_data;
   ctr_vec_type          ctr_rd_data;
   logic [NUM_CTR*CTR_W-1:0] ctr_rd_raw;
   ctr_vec_type          ctr_wr_data;

   // Copy of the accepted request, feeds the snapshot write
   req_type hold_req_ff;

   assign ctr_wr_data = req_counters(hold_req_ff);
   assign ctr_rd_data = ctr_rd_raw;

   rwps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rwps_seq #(
      .RING_DEPTH (RING_DEPTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .mem_wr_en    (mem_wr_en),
      .mem_wr_addr  (mem_wr_addr),
      .mem_rd_addr  (mem_rd_addr),
      .time_rd_data (time_rd_data),
      .ctr_rd_data  (ctr_rd_data)
   );

   // Hold the accepted request for the snapshot write
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         hold_req_ff <= req_data;
      end
   end

   // Snapshot timestamps
   rwps_ram #(
      .WIDTH (TIME_W),
      .DEPTH (RING_DEPTH)
   ) u_time_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (hold_req_ff.now_ms),
      .rd_addr (mem_rd_addr),
      .rd_data (time_rd_data)
   );

   // Snapshot counters, all eight in one row
   rwps_ram #(
      .WIDTH (NUM_CTR * CTR_W),
      .DEPTH (RING_DEPTH)
   ) u_ctr_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (ctr_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (ctr_rd_raw)
   );

endmodule

`default_nettype wire

### src/rwps_checker.sv
// ----------------------------------------------------------------------------
// rwps_checker
// Port level checks for rolling_window_packet_stats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rwps_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire rwps_pkg::rsp_type rsp_data
);

   // One request in flight: an accepted beat closes the request side
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while previous one in flight");

   // A new response only follows a busy cycle
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response appeared without a request in flight");

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // Reset empties the output register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind rolling_window_packet_stats rwps_checker u_rwps_checker (.*);

`default_nettype wire

### sim/rolling_window_packet_stats_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rolling_window_packet_stats_tb
// Self-checking bench for the rolling window packet statistics block.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own snapshot ring, scan and window settings and
// works out the rolling counter deltas for every accepted request beat.
// Response beats are compared field by field against the oldest prediction.
// Directed requests cover disable, scan interval, window expiry, time wrap,
// time running backwards, zero window and extreme settings; random traffic
// then runs the ring through stale drops, overflow and noise under random
// valid gaps and response stalls.
// ----------------------------------------------------------------------------

module rolling_window_packet_stats_tb;
   import rwps_pkg::*;

   localparam int RING          = DEFAULT_RING_DEPTH;
   localparam int ROW_W         = NUM_CTR * CTR_W;
   localparam int SETTLE_CYCLES = 4 + RING + 12;
   localparam int LIMIT_CYCLES  = 1000000;
   localparam int MAX_PRINTED   = 40;

   // Index past the last register: writes to it must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // Eight counters side by side, element 0 = local good at the MSB end
   typedef logic [0:NUM_CTR-1][CTR_W-1:0] counter_row;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_ENABLE;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   rolling_window_packet_stats dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scoreboard copy of the block's settings and snapshot ring
   bit                 cfg_enable = 1'b0;
   logic [TIME_W-1:0]  cfg_scan   = SCAN_INTERVAL_RESET;
   logic [TIME_W-1:0]  cfg_window = WINDOW_RESET;
   logic [TIME_W-1:0]  snap_at [RING];
   counter_row         snap_row [RING];
   int unsigned        ring_head = 0;
   int unsigned        ring_fill = 0;
   logic [TIME_W-1:0]  last_snap_time = '0;
   bit                 have_snap = 1'b0;
   counter_row         roll_held = '0;
   rsp_type            pending_rolls [$];

   // Traffic state for well-formed sequences
   logic [TIME_W-1:0]  run_time = '0;
   counter_row         run_row  = '0;
   bit                 no_idle  = 1'b0;

   int unsigned cycle_count = 0;
   int unsigned mismatches  = 0;
   int unsigned req_beats   = 0;
   int unsigned rsp_beats   = 0;
   int unsigned snap_beats  = 0;
   int unsigned csr_writes  = 0;

   string ctr_name [NUM_CTR] = '{"roll_local_good", "roll_local_late", "roll_local_lost",
                                 "roll_local_resync", "roll_remote_good", "roll_remote_late",
                                 "roll_remote_lost", "roll_remote_resync"};

   function automatic req_type make_req(input logic [TIME_W-1:0] t, input counter_row row);
      return req_type'({t, row});
   endfunction

   // Mostly no gap, often a short one, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Apply one request to the scoreboard ring and return the expected beat
   function automatic rsp_type advance_window(input req_type r);
      logic [$bits(req_type)-1:0] flat;
      counter_row                 cur;
      logic [TIME_W-1:0]          age;
      int unsigned                slot;
      bit                         took;
      flat = r;
      cur  = counter_row'(flat[ROW_W-1:0]);
      age  = r.now_ms - last_snap_time;
      took = cfg_enable && (!have_snap || age >= cfg_scan);
      if (took) begin
         have_snap      = 1'b1;
         last_snap_time = r.now_ms;
         // make room: a full ring loses its oldest snapshot
         if (ring_fill == RING) begin
            ring_head = (ring_head + 1) % RING;
            ring_fill = RING - 1;
         end
         slot           = (ring_head + ring_fill) % RING;
         snap_at[slot]  = r.now_ms;
         snap_row[slot] = cur;
         ring_fill++;
         // drop snapshots that have aged out of the window
         age = r.now_ms - snap_at[ring_head];
         while (ring_fill > 0 && age > cfg_window) begin
            ring_head = (ring_head + 1) % RING;
            ring_fill--;
            age = r.now_ms - snap_at[ring_head];
         end
         for (int k = 0; k < NUM_CTR; k++)
            roll_held[k] = cur[k] - snap_row[ring_head][k];
      end
      return rsp_type'({took, roll_held});
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Send one request beat and log its prediction once accepted
   task automatic send_req(input req_type r);
      int unsigned gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      pending_rolls.push_back(advance_window(r));
      req_beats++;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ENABLE:        cfg_enable = data[0];
         CSR_SCAN_INTERVAL: cfg_scan   = data;
         CSR_WINDOW:        cfg_window = data;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait for every outstanding response, then let the block settle
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rolls.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Well-formed counter sequences with a share of random noise beats
   task automatic run_traffic(input int n, input int unsigned step_max,
                              input int unsigned noise_pct);
      req_type    r;
      counter_row noise_row;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < noise_pct) begin
            for (int k = 0; k < NUM_CTR; k++)
               noise_row[k] = $urandom;
            r = make_req($urandom, noise_row);
         end else begin
            run_time += $urandom_range(0, step_max);
            for (int k = 0; k < NUM_CTR; k++)
               run_row[k] += ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 3000);
            r = make_req(run_time, run_row);
         end
         send_req(r);
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_disabled_after_reset();
      csr_write(CSR_SPARE, '1);
      send_req(make_req('0, '0));
      send_req(make_req('1, '1));
      send_req(make_req(32'h5555_5555, {NUM_CTR{32'hAAAA_AAAA}}));
      send_req(make_req(32'hAAAA_AAAA, {NUM_CTR{32'h5555_5555}}));
      drain();
   endtask

   task automatic test_scan_interval();
      csr_write(CSR_ENABLE, 32'd1);
      send_req(make_req(32'd1000, {NUM_CTR{32'd100}}));
      send_req(make_req(32'd5999, {NUM_CTR{32'd200}}));
      send_req(make_req(32'd6000, {NUM_CTR{32'd300}}));
      send_req(make_req(32'd6000, {NUM_CTR{32'd400}}));
      drain();
   endtask

   task automatic test_window_expiry();
      send_req(make_req(32'd306000, {NUM_CTR{32'd500}}));
      send_req(make_req(32'd306001, {NUM_CTR{32'd600}}));
      send_req(make_req(32'd311000, {NUM_CTR{32'd700}}));
      drain();
   endtask

   task automatic test_time_wrap_and_backwards();
      send_req(make_req(32'hFFFF_F000, {NUM_CTR{32'hFFFF_FF00}}));
      send_req(make_req(32'h0000_0400, {NUM_CTR{32'h0000_0100}}));
      // time steps back: the huge age still counts as elapsed
      send_req(make_req(32'h0000_0100, {NUM_CTR{32'h0000_0180}}));
      drain();
   endtask

   task automatic test_zero_window();
      csr_write(CSR_SCAN_INTERVAL, '0);
      csr_write(CSR_WINDOW, '0);
      send_req(make_req(32'd500, {NUM_CTR{32'd10}}));
      send_req(make_req(32'd500, {NUM_CTR{32'd25}}));
      send_req(make_req(32'd501, {NUM_CTR{32'd40}}));
      drain();
   endtask

   task automatic test_extreme_settings();
      csr_write(CSR_SCAN_INTERVAL, '1);
      csr_write(CSR_WINDOW, '1);
      send_req(make_req(32'd1000, {NUM_CTR{32'd50}}));
      send_req(make_req(32'd500, {NUM_CTR{32'd90}}));
      drain();
      csr_write(CSR_ENABLE, '0);
      send_req(make_req(32'h0000_9000, '1));
      drain();
   endtask

   task automatic test_stale_drop_churn();
      csr_write(CSR_ENABLE, 32'd1);
      csr_write(CSR_SCAN_INTERVAL, $urandom_range(0, 20));
      csr_write(CSR_WINDOW, $urandom_range(200, 800));
      run_time = $urandom;
      run_traffic(280, 100, 5);
      drain();
   endtask

   task automatic test_ring_overflow();
      csr_write(CSR_SCAN_INTERVAL, '0);
      csr_write(CSR_WINDOW, '1);
      no_idle = 1'b1;
      run_traffic(250, 3, 5);
      drain();
      no_idle = 1'b0;
   endtask

   task automatic test_default_spacing();
      csr_write(CSR_SCAN_INTERVAL, SCAN_INTERVAL_RESET);
      csr_write(CSR_WINDOW, WINDOW_RESET);
      // start just short of the time wrap
      run_time = 32'hFFF0_0000;
      run_traffic(250, 12000, 5);
      drain();
   endtask

   task automatic test_zero_window_traffic();
      csr_write(CSR_SCAN_INTERVAL, $urandom_range(0, 2));
      csr_write(CSR_WINDOW, '0);
      run_traffic(200, 2, 5);
      drain();
   endtask

   task automatic test_enable_toggle();
      for (int round = 0; round < 3; round++) begin
         csr_write(CSR_ENABLE, (round % 2 == 0) ? 32'd0 : 32'd1);
         csr_write(CSR_SCAN_INTERVAL, $urandom_range(0, 50));
         csr_write(CSR_WINDOW, $urandom_range(0, 3000));
         run_traffic(50, 60, 5);
         drain();
      end
   endtask

   task automatic test_random_noise();
      csr_write(CSR_ENABLE, 32'd1);
      csr_write(CSR_SCAN_INTERVAL, $urandom);
      csr_write(CSR_WINDOW, $urandom);
      run_traffic(125, 0, 100);
      drain();
      csr_write(CSR_SCAN_INTERVAL, $urandom_range(0, 1000));
      csr_write(CSR_WINDOW, $urandom);
      run_traffic(125, 0, 100);
      drain();
   endtask

   // ---------------------------------------------------------------- checking

   // Compare each accepted response beat with the oldest prediction
   always @(posedge clock) begin
      rsp_type                    want;
      logic [$bits(rsp_type)-1:0] flat_got;
      logic [$bits(rsp_type)-1:0] flat_want;
      counter_row                 got_row;
      counter_row                 want_row;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_beats++;
         if (rsp_data.sampled === 1'b1)
            snap_beats++;
         if (pending_rolls.size() == 0) begin
            note_mismatch("response beat with no request outstanding");
         end else begin
            want      = pending_rolls.pop_front();
            flat_got  = rsp_data;
            flat_want = want;
            got_row   = counter_row'(flat_got[ROW_W-1:0]);
            want_row  = counter_row'(flat_want[ROW_W-1:0]);
            if (rsp_data.sampled !== want.sampled)
               note_mismatch($sformatf("sampled: got %b, want %b",
                                       rsp_data.sampled, want.sampled));
            for (int k = 0; k < NUM_CTR; k++)
               if (got_row[k] !== want_row[k])
                  note_mismatch($sformatf("%s: got %h, want %h",
                                          ctr_name[k], got_row[k], want_row[k]));
         end
      end
   end

   // Stall the response side in random stretches
   initial begin
      int unsigned n;
      forever begin
         @(negedge clock);
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_disabled_after_reset();
      test_scan_interval();
      test_window_expiry();
      test_time_wrap_and_backwards();
      test_zero_window();
      test_extreme_settings();
      test_stale_drop_churn();
      test_ring_overflow();
      test_default_spacing();
      test_zero_window_traffic();
      test_enable_toggle();
      test_random_noise();

      if (pending_rolls.size() != 0)
         note_mismatch($sformatf("%0d responses never arrived", pending_rolls.size()));

      $display("Sent %0d request beats over %0d register writes; %0d response beats checked,",
               req_beats, csr_writes, rsp_beats);
      $display("%0d of them with a stored snapshot; %0d mismatches.", snap_beats, mismatches);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

### files.f
src/rwps_pkg.sv
src/rwps_ram.sv
src/rwps_csr.sv
src/rwps_seq.sv
src/rolling_window_packet_stats.sv
src/rwps_checker.sv
sim/rolling_window_packet_stats_tb.sv
